>>> sv/lfo_pkg.sv
package lfo_pkg;

   // Configuration port geometry.
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP = 2'd0,
      CSR_WAVE_SHAPE = 2'd1,
      CSR_MOD_DEPTH  = 2'd2
   } lfo_csr_index_type;

   // Waveform selection codes.
   typedef enum logic [1:0] {
      SHAPE_TRIANGLE = 2'd0,
      SHAPE_SQUARE   = 2'd1,
      SHAPE_SINE     = 2'd2
   } lfo_shape_type;

   localparam int        STEP_BITS  = 32;
   localparam int        DEPTH_BITS = 16;
   localparam int        DEPTH_FRAC = 15;
   localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = 16'h8000;

   // Settings that the back end reads while it works.
   typedef struct packed {
      lfo_shape_type          shape;
      logic [DEPTH_BITS-1:0]  depth;
   } lfo_cfg_type;

   // Queue between the front and the back end.
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // Quarter pi in Q30 times two, i.e. pi/2 in Q30.
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned Q30         = 64'd1 << 30;

   // Sine table entry k of a quarter wave with 2^tbits steps, rounded to
   // frac fraction bits and clamped to one. Evaluated at elaboration only.
   function automatic logic [31:0] sine_q(input int unsigned k, input int tbits,
                                          input int frac);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned v;
      longint unsigned one;
      int              sh;
      one  = 64'd1 << frac;
      sh   = 30 - frac;
      x    = ((64'(k)) * HALF_PI_Q30) >> tbits;
      x2   = (x * x) >> 30;
      term = Q30 - x2 / 72;
      term = Q30 - ((x2 * term) >> 30) / 42;
      term = Q30 - ((x2 * term) >> 30) / 20;
      term = Q30 - ((x2 * term) >> 30) / 6;
      v    = (x * term) >> 30;
      v    = (v + (64'd1 << (sh - 1))) >> sh;
      if (v > one) begin
         v = one;
      end
      return 32'(v);
   endfunction

endpackage

>>> sv/lfo_front.sv
module lfo_front
   import lfo_pkg::*;
#(
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_restart,
   output logic                  req_stall,
   input  logic [STEP_BITS-1:0]  phase_step,
   input  logic                  queue_full,
   output logic                  push,
   output logic [PHASE_BITS-1:0] push_phase
);

   logic [PHASE_BITS-1:0] phase_acc_ff;
   logic [PHASE_BITS-1:0] phase_acc_in;

   // An item is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // A restart clears the phase before this item's sample is formed.
   assign push_phase   = req_restart ? '0 : phase_acc_ff;
   assign phase_acc_in = push_phase + PHASE_BITS'(phase_step);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else if (push) begin
         phase_acc_ff <= phase_acc_in;
      end
   end

endmodule

>>> sv/lfo_queue.sv
module lfo_queue
   import lfo_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]          entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] head_ff;
   logic [QUEUE_PTR_BITS-1:0] head_in;
   logic [QUEUE_PTR_BITS-1:0] tail_ff;
   logic [QUEUE_PTR_BITS-1:0] tail_in;
   logic [QUEUE_PTR_BITS:0]   count_ff;
   logic [QUEUE_PTR_BITS:0]   count_in;

   assign full     = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[head_ff];

   // Pointer and fill count updates.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Payload storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

endmodule

>>> sv/lfo_back.sv
module lfo_back
   import lfo_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_BITS        = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_empty,
   input  logic [PHASE_BITS-1:0]      phase,
   output logic                       pop,
   input  lfo_cfg_type                cfg,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_lfo_value
);

   localparam int FRAC      = OUT_BITS - 1;
   localparam int ROM_N     = 1 << SINE_TABLE_BITS;
   localparam int PROD_BITS = OUT_BITS + DEPTH_BITS;
   localparam logic [FRAC+2:0]   ONE_W   = (FRAC+3)'(1) << FRAC;
   localparam logic [FRAC+2:0]   THREE_W = ONE_W + (ONE_W << 1);
   localparam logic [OUT_BITS-1:0] ONE_MAG = OUT_BITS'(1) << FRAC;
   localparam logic [OUT_BITS-1:0] MAX_POS = ONE_MAG - 1'b1;

   // Quarter-wave sine table, folded to constants at elaboration.
   logic [OUT_BITS-1:0] rom_tab [0:ROM_N];

   for (genvar k = 0; k <= ROM_N; k++) begin : g_rom
      assign rom_tab[k] = OUT_BITS'(sine_q(32'(k), SINE_TABLE_BITS, FRAC));
   end

   logic                        adv;
   logic                        a_valid_ff;
   logic                        a_neg_ff;
   logic                        a_neg_in;
   logic [OUT_BITS-1:0]         a_mag_ff;
   logic [OUT_BITS-1:0]         a_mag_in;
   logic                        b_valid_ff;
   logic                        b_neg_ff;
   logic [PROD_BITS-1:0]        b_prod_ff;
   logic [PROD_BITS-1:0]        b_prod_in;
   logic                        out_valid_ff;
   logic signed [OUT_BITS-1:0]  out_value_ff;
   logic signed [OUT_BITS-1:0]  out_value_in;

   logic                          top_bit;
   logic [1:0]                    quad;
   logic [SINE_TABLE_BITS-1:0]    sine_idx;
   logic [SINE_TABLE_BITS:0]      sine_addr;
   logic [PHASE_BITS+FRAC+1:0]    phase_ext;
   logic [FRAC+1:0]               tri_x;
   logic [FRAC+2:0]               tri_s;
   logic [FRAC+2:0]               tri_abs;
   logic [DEPTH_BITS-1:0]         depth_c;
   logic [OUT_BITS:0]             scaled;

   // The whole pipeline moves when the output register can take a new item.
   assign adv = !out_valid_ff || !rsp_stall;
   assign pop = adv && !queue_empty;

   // Stage A: form the sample magnitude and sign from the phase.
   assign top_bit   = phase[PHASE_BITS-1];
   assign quad      = phase[PHASE_BITS-1 -: 2];
   assign sine_idx  = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];
   assign sine_addr = quad[0] ? ((SINE_TABLE_BITS+1)'(ROM_N) - {1'b0, sine_idx})
                              : {1'b0, sine_idx};
   assign phase_ext = {phase, {(FRAC+2){1'b0}}};
   assign tri_x     = phase_ext[PHASE_BITS+FRAC+1 -: FRAC+2];
   assign tri_s     = top_bit ? (THREE_W - {1'b0, tri_x}) : ({1'b0, tri_x} - ONE_W);
   assign tri_abs   = tri_s[FRAC+2] ? ('0 - tri_s) : tri_s;

   always_comb begin
      case (cfg.shape)
         SHAPE_TRIANGLE: begin
            a_mag_in = tri_abs[OUT_BITS-1:0];
            a_neg_in = tri_s[FRAC+2];
         end
         SHAPE_SQUARE: begin
            a_mag_in = ONE_MAG;
            a_neg_in = top_bit;
         end
         SHAPE_SINE: begin
            a_mag_in = rom_tab[sine_addr];
            a_neg_in = quad[1];
         end
         default: begin
            a_mag_in = '0;
            a_neg_in = 1'b0;
         end
      endcase
   end

   // Stage B: scale by the depth, clamped to one.
   assign depth_c   = cfg.depth[DEPTH_BITS-1] ? DEPTH_ONE : cfg.depth;
   assign b_prod_in = PROD_BITS'(a_mag_ff) * PROD_BITS'(depth_c);

   // Stage C: truncate toward zero, restore the sign and saturate.
   assign scaled = b_prod_ff[PROD_BITS-1:DEPTH_FRAC];

   always_comb begin
      if (b_neg_ff) begin
         out_value_in = OUT_BITS'((OUT_BITS+1)'(0) - scaled);
      end else if (scaled >= (OUT_BITS+1)'(ONE_MAG)) begin
         out_value_in = MAX_POS;
      end else begin
         out_value_in = scaled[OUT_BITS-1:0];
      end
   end

   // Stage valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff   <= pop;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   // Stage payloads.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_neg_ff     <= a_neg_in;
         a_mag_ff     <= a_mag_in;
         b_neg_ff     <= a_neg_ff;
         b_prod_ff    <= b_prod_in;
         out_value_ff <= out_value_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_lfo_value = out_value_ff;

endmodule

>>> sv/lfo_waveform_generator.sv
// An accepted item passes the queue and the stage A, stage B and output registers
// before its result is shown. Throughput: one item per cycle while no result is
// stalled; the queue holds four items and the back end pipeline of sample lookup,
// depth multiply and saturation takes one per cycle. A stalled result stalls the
// back end pipeline; the front keeps filling the queue. Reset (synchronous, active
// high) zeroes the phase and configuration and empties the queue and the pipeline.
module lfo_waveform_generator
   import lfo_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_TABLE_BITS = 10,
   parameter int OUT_BITS        = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_restart,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OUT_BITS-1:0] rsp_lfo_value,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   logic [STEP_BITS-1:0]  phase_step_ff;
   lfo_shape_type         wave_shape_ff;
   logic [DEPTH_BITS-1:0] mod_depth_ff;
   lfo_cfg_type           cfg;

   logic                  push;
   logic [PHASE_BITS-1:0] push_phase;
   logic                  pop;
   logic [PHASE_BITS-1:0] pop_phase;
   logic                  queue_full;
   logic                  queue_empty;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         wave_shape_ff <= SHAPE_TRIANGLE;
         mod_depth_ff  <= '0;
      end else if (csr_write) begin
         case (lfo_csr_index_type'(csr_index))
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[STEP_BITS-1:0];
            CSR_WAVE_SHAPE: wave_shape_ff <= lfo_shape_type'(csr_wdata[1:0]);
            CSR_MOD_DEPTH:  mod_depth_ff  <= csr_wdata[DEPTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.shape = wave_shape_ff;
   assign cfg.depth = mod_depth_ff;

   lfo_front #(
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .phase_step  (phase_step_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_phase  (push_phase)
   );

   lfo_queue #(
      .WIDTH (PHASE_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_phase),
      .pop       (pop),
      .pop_data  (pop_phase),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   lfo_back #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS),
      .OUT_BITS        (OUT_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .phase         (pop_phase),
      .pop           (pop),
      .cfg           (cfg),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_lfo_value (rsp_lfo_value)
   );

endmodule

>>> sv/lfo_checker.sv
module lfo_checker
   import lfo_pkg::*;
#(
   parameter int OUT_BITS = 16
) (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [OUT_BITS-1:0] rsp_lfo_value,
   input logic                       csr_write,
   input logic [CSR_INDEX_BITS-1:0]  csr_index,
   input logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   logic depth_zero_ff;

   // Track whether the depth register holds zero; reset leaves it at zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_zero_ff <= 1'b1;
      end else if (csr_write && (csr_index == CSR_MOD_DEPTH)) begin
         depth_zero_ff <= (csr_wdata[DEPTH_BITS-1:0] == '0);
      end
   end

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_lfo_value))
      else $error("result changed while stalled");

   // Reset empties the pipeline.
   a_reset_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // Reset empties the queue, so the input side is open.
   a_reset_req: assert property (@(posedge clock)
      $past(reset) |-> !req_stall)
      else $error("input stalled right after reset");

   // Zero depth scales every sample to zero.
   a_zero_depth: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && depth_zero_ff |-> rsp_lfo_value == '0)
      else $error("nonzero result at zero depth");

endmodule

bind lfo_waveform_generator lfo_checker #(.OUT_BITS(OUT_BITS)) u_lfo_checker (.*);

>>> dv/lfo_waveform_generator_tb.sv
`timescale 1ns / 100ps

module lfo_waveform_generator_tb;
   import lfo_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int RANDOM_ITEMS  = 550;
   localparam int DRAIN_CYCLES  = 4;
   localparam int TABLE_N       = 1024;
   localparam int SAMPLE_ONE    = 32768;
   localparam int DIR_ROWS      = 25;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED      = 2'd3;
   localparam logic [1:0]                SHAPE_UNDEFINED = 2'd3;
   localparam logic [31:0]               HALF_TURN       = 32'h8000_0000;
   localparam logic [31:0]               QUARTER_TURN    = 32'h4000_0000;
   localparam logic signed [15:0]        MIN_VALUE       = 16'sh8000;
   localparam logic signed [15:0]        MAX_VALUE       = 16'sh7FFF;

   // One directed tick: optional register load, then one item.
   typedef struct packed {
      logic               load;
      logic [31:0]        step;
      logic [31:0]        shape_word;
      logic [31:0]        depth_word;
      logic               restart;
      logic               fixed;
      logic signed [15:0] value;
   } tick_row_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   logic signed [15:0]  rsp_lfo_value;
   logic                csr_write   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Oscillator state as the predictor sees it.
   logic [31:0]         acc_phase  = '0;
   logic [31:0]         step_reg   = '0;
   logic [1:0]          shape_reg  = '0;
   logic [15:0]         depth_reg  = '0;
   int                  sine_tbl [0:TABLE_N];

   logic signed [15:0]  expected_lfo [$];
   int                  failures     = 0;
   int                  cycle_count  = 0;
   int                  stall_left   = 0;
   bit                  sender_idles   = 1'b1;
   bit                  receiver_idles = 1'b1;

   tick_row_type dir_rows [DIR_ROWS] = '{
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd0},
      '{1'b1, 32'd0, 32'(SHAPE_TRIANGLE), 32'(DEPTH_ONE), 1'b1, 1'b1, MIN_VALUE},
      '{1'b1, HALF_TURN, 32'(SHAPE_SQUARE), 32'(DEPTH_ONE), 1'b1, 1'b1, MAX_VALUE},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, MIN_VALUE},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, MAX_VALUE},
      '{1'b1, QUARTER_TURN, 32'(SHAPE_TRIANGLE), 32'(DEPTH_ONE), 1'b1, 1'b1, MIN_VALUE},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, MAX_VALUE},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, MIN_VALUE},
      '{1'b1, QUARTER_TURN, 32'hFFFF_FFF6, 32'hABCD_8000, 1'b1, 1'b0, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
      '{1'b1, HALF_TURN, 32'(SHAPE_SQUARE), 32'h0000_FFFF, 1'b1, 1'b1, MAX_VALUE},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, MIN_VALUE},
      '{1'b1, HALF_TURN, 32'(SHAPE_UNDEFINED), 32'(DEPTH_ONE), 1'b1, 1'b1, 16'sd0},
      '{1'b1, HALF_TURN, 32'(SHAPE_SQUARE), 32'h0000_4000, 1'b1, 1'b1, 16'sd16384},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, -16'sd16384},
      '{1'b1, 32'hFFFF_FFFF, 32'(SHAPE_TRIANGLE), 32'd1, 1'b1, 1'b0, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
      '{1'b1, 32'h0123_4567, 32'(SHAPE_SINE), 32'h0000_5555, 1'b0, 1'b0, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
      '{1'b1, 32'h7FFF_FFFF, 32'(SHAPE_TRIANGLE), 32'd0, 1'b0, 1'b1, 16'sd0},
      '{1'b0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd0}
   };

   lfo_waveform_generator uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_restart   (req_restart),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_lfo_value (rsp_lfo_value),
      .csr_write     (csr_write),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #2 clock = ~clock;

   // Quarter-wave sine entry k: integer Taylor series in Q30, rounded to Q15.
   function automatic int quarter_sine(input int k);
      longint unsigned ang;
      longint unsigned sq;
      longint unsigned ser;
      longint unsigned v;
      ang = (64'(k) * HALF_PI_Q30) >> 10;
      sq  = (ang * ang) >> 30;
      ser = Q30 - sq / 72;
      ser = Q30 - ((sq * ser) >> 30) / 42;
      ser = Q30 - ((sq * ser) >> 30) / 20;
      ser = Q30 - ((sq * ser) >> 30) / 6;
      v   = (ang * ser) >> 30;
      v   = (v + (64'd1 << 14)) >> 15;
      if (v > 64'(SAMPLE_ONE)) begin
         v = 64'(SAMPLE_ONE);
      end
      return int'(v);
   endfunction

   initial begin
      for (int k = 0; k <= TABLE_N; k++) begin
         sine_tbl[k] = quarter_sine(k);
      end
   end

   // Register write as the block sees it; unknown indexes are dropped.
   function automatic void update_settings(input logic [CSR_INDEX_BITS-1:0] idx,
                                           input logic [31:0] data);
      case (idx)
         CSR_PHASE_STEP: step_reg  = data;
         CSR_WAVE_SHAPE: shape_reg = data[1:0];
         CSR_MOD_DEPTH:  depth_reg = data[15:0];
         default: ;
      endcase
   endfunction

   // One tick: clear the phase on restart, form the sample, scale, saturate, advance.
   function automatic logic signed [15:0] next_lfo_value(input logic restart);
      int          sample;
      longint      mag;
      longint      scaled;
      int unsigned gain;
      logic [16:0] ramp;
      logic [9:0]  idx;
      logic [1:0]  quad;
      if (restart) begin
         acc_phase = '0;
      end
      ramp = acc_phase[31:15];
      quad = acc_phase[31:30];
      idx  = acc_phase[29:20];
      case (shape_reg)
         SHAPE_TRIANGLE: sample = quad[1] ? 3 * SAMPLE_ONE - int'(ramp)
                                          : int'(ramp) - SAMPLE_ONE;
         SHAPE_SQUARE:   sample = quad[1] ? -SAMPLE_ONE : SAMPLE_ONE;
         SHAPE_SINE: begin
            sample = quad[0] ? sine_tbl[TABLE_N - int'(idx)] : sine_tbl[int'(idx)];
            if (quad[1]) begin
               sample = -sample;
            end
         end
         default: sample = 0;
      endcase
      gain   = (depth_reg > DEPTH_ONE) ? 32'(DEPTH_ONE) : 32'(depth_reg);
      mag    = (longint'(sample < 0 ? -sample : sample) * longint'(gain)) >>> DEPTH_FRAC;
      scaled = (sample < 0) ? -mag : mag;
      if (scaled > SAMPLE_ONE - 1) begin
         scaled = SAMPLE_ONE - 1;
      end
      if (scaled < -SAMPLE_ONE) begin
         scaled = -SAMPLE_ONE;
      end
      acc_phase = acc_phase + step_reg;
      return 16'(scaled);
   endfunction

   // Drive one register write and mirror it once it lands.
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      update_settings(idx, data);
   endtask

   task automatic apply_settings(input logic [31:0] step, input logic [31:0] shape_word,
                                 input logic [31:0] depth_word);
      write_reg(CSR_UNUSED, $urandom);
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_WAVE_SHAPE, shape_word);
      write_reg(CSR_MOD_DEPTH, depth_word);
      csr_write <= 1'b0;
   endtask

   // Offer one item after a random gap if the sender idles; hold it until accepted.
   task automatic send_item(input logic restart, input logic fixed,
                            input logic signed [15:0] value);
      int                 gap;
      logic signed [15:0] pred;
      gap = sender_idles ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pred = next_lfo_value(restart);
      expected_lfo.push_back(fixed ? value : pred);
   endtask

   // Stop sending and wait until every expected item has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_lfo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result side: check each accepted item, then draw the next stall.
   always @(posedge clock) begin
      logic signed [15:0] want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lfo.size() == 0) begin
            $error("unexpected result: lfo_value actual %0d", rsp_lfo_value);
            failures++;
         end else begin
            want = expected_lfo.pop_front();
            if (rsp_lfo_value !== want) begin
               $error("lfo_value mismatch: expected %0d, actual %0d", want, rsp_lfo_value);
               failures++;
            end
         end
         stall_left = receiver_idles ? $urandom_range(0, 15) : 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end
      rsp_stall <= (stall_left != 0);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      tick_row_type row;
      int           random_sent;
      int           burst;
      logic [31:0]  step;
      logic [1:0]   shape;
      logic [15:0]  depth;
      random_sent = 0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks: defaults after reset, extremes and the special cases.
      for (int r = 0; r < DIR_ROWS; r++) begin
         row = dir_rows[r];
         if (row.load) begin
            wait_drained();
            apply_settings(row.step, row.shape_word, row.depth_word);
         end
         send_item(row.restart, row.fixed, row.value);
      end

      // Random bursts, each under fresh settings loaded while the block is idle.
      while (random_sent < RANDOM_ITEMS) begin
         wait_drained();
         case ($urandom_range(0, 5))
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            2:       step = $urandom_range(1, 1 << 20);
            3:       step = HALF_TURN + $urandom_range(0, 255);
            default: step = $urandom;
         endcase
         shape = ($urandom_range(0, 9) == 0) ? SHAPE_UNDEFINED : 2'($urandom_range(0, 2));
         case ($urandom_range(0, 5))
            0:       depth = 16'd0;
            1:       depth = DEPTH_ONE;
            2:       depth = 16'hFFFF;
            3:       depth = 16'($urandom_range(32769, 65535));
            default: depth = 16'($urandom_range(0, 32768));
         endcase
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         apply_settings(step, {30'($urandom), shape},
                        {16'($urandom), depth});
         burst = $urandom_range(20, 60);
         repeat (burst) begin
            send_item($urandom_range(0, 9) == 0, 1'b0, 16'sd0);
            random_sent++;
         end
      end

      wait_drained();
      if (expected_lfo.size() != 0) begin
         $error("%0d expected lfo_value items never arrived", expected_lfo.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/lfo_pkg.sv
sv/lfo_front.sv
sv/lfo_queue.sv
sv/lfo_back.sv
sv/lfo_waveform_generator.sv
sv/lfo_checker.sv
dv/lfo_waveform_generator_tb.sv
